[rtl/steering_kalman_frame_encoder_assert.svh]
// Assertion macros used by the steering Kalman frame encoder checker.
`ifndef STEERING_KALMAN_FRAME_ENCODER_ASSERT_SVH
`define STEERING_KALMAN_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SKFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SKFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/skfe_pkg.sv]
// Shared constants, register indexes and control types of the steering Kalman frame encoder.
package skfe_pkg;

  // Default number of fraction bits of the angle format.
  localparam int FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int RAW_W    = 32;
  localparam int SCALE_W  = 20;
  localparam int FILT_W   = 27;
  localparam int GAIN_W   = 17;
  localparam int CODE_W   = 14;
  localparam int FRAME_W  = 48;
  localparam int COV_W    = 32;

  // Stream word widths.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = FILT_W + GAIN_W + CODE_W + FRAME_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_TURN_SCALE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_ESTIMATE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_ERROR    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MEAS_NOISE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PROC_NOISE    = 3'd4;

  // Register reset values.
  localparam logic [SCALE_W-1:0] TURN_SCALE_RST = 20'd256;
  localparam logic [COV_W-1:0]   INIT_ERROR_RST = 32'd65536;
  localparam logic [COV_W-1:0]   MEAS_NOISE_RST = 32'd65536;
  localparam logic [COV_W-1:0]   PROC_NOISE_RST = 32'd655;

  // Angle limit in whole degrees and the code ceiling.
  localparam int ANGLE_INT = 779;
  localparam int CODE_MAX  = 15580;

  // Gain of exactly one in Q1.16.
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

  // Number of quotient bits produced by the divider, one per cycle.
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = 5;

  // Serial frame bytes.
  localparam logic [7:0] FRAME_SYNC0 = 8'h5A;
  localparam logic [7:0] FRAME_SYNC1 = 8'hA5;
  localparam logic [7:0] FRAME_CMD   = 8'h02;
  localparam logic [7:0] FRAME_TAIL  = 8'hAA;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;     // capture raw sample and start the scale multiply
    logic clamp;       // scale shift and clamp into the sample register
    logic predict;     // grow the covariance and set up the divider
    logic div_step;    // one restoring division step
    logic kmul;        // latch the gain and form gain times innovation
    logic commit;      // update estimate and covariance
    logic code_mul;    // offset estimate and multiply by ten
    logic out_load;    // load the result word
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;    // current division step is the final one
  } sts_t;

endpackage

[rtl/skfe_ctrl.sv]
// Controller state machine that sequences one item through the datapath.
module skfe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  skfe_pkg::sts_t   sts,
  output skfe_pkg::cmd_t   cmd
);
  import skfe_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLAMP  = 3'd1;
  localparam logic [2:0] ST_PRED   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_KMUL   = 3'd4;
  localparam logic [2:0] ST_COMMIT = 3'd5;
  localparam logic [2:0] ST_CODE   = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The result register can take a new word when empty or being drained.
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ST_PRED;
      end
      ST_PRED: begin
        cmd.predict = 1'b1;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_KMUL;
        end
      end
      ST_KMUL: begin
        cmd.kmul  = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_CODE;
      end
      ST_CODE: begin
        cmd.code_mul = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid flag: set on load, cleared when the word is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/skfe_dp.sv]
// Datapath: scaling, clamp, Kalman predict and update, divider, code and frame.
module skfe_dp #(
  parameter int FRAC_BITS = skfe_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [skfe_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              cfg_we,
  input  logic [skfe_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [skfe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  skfe_pkg::cmd_t                    cmd,
  output skfe_pkg::sts_t                    sts,
  output logic [skfe_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import skfe_pkg::*;

  // Angle width holds the clamp limit and any loaded initial estimate.
  localparam int AW = (FRAC_BITS + 11 > FILT_W) ? FRAC_BITS + 11 : FILT_W;
  localparam int PW = RAW_W + SCALE_W;
  localparam int SW = PW - 8;
  localparam int KW = AW + 19;
  localparam int CW = AW + 5;
  localparam int QW = CW - FRAC_BITS;
  localparam longint LIM = longint'(ANGLE_INT) << FRAC_BITS;
  localparam logic signed [SW-1:0] LIM_S = SW'(LIM);
  localparam logic signed [AW-1:0] LIM_A = AW'(LIM);
  localparam logic signed [AW:0]   LIM_P = (AW + 1)'(LIM);

  // Configuration and filter state.
  logic signed [SCALE_W-1:0] turn_scale_r;
  logic [COV_W-1:0]          meas_noise_r;
  logic [COV_W-1:0]          proc_noise_r;
  logic signed [AW-1:0]      est_r, est_nxt;
  logic [COV_W-1:0]          cov_r, cov_nxt;

  // Working registers.
  logic signed [PW-1:0]      prod_r;
  logic signed [AW-1:0]      sample_r, sample_nxt;
  logic [COV_W-1:0]          err_r, err_nxt;
  logic [COV_W:0]            den_r, den_nxt;
  logic [COV_W+1:0]          rem_r, rem_nxt;
  logic [GAIN_W-1:0]         quo_r;
  logic [DIV_CNT_W-1:0]      cnt_r;
  logic [GAIN_W-1:0]         gain_r, gain_w;
  logic signed [KW-1:0]      kprod_r;
  logic signed [CW-1:0]      pos10_r;
  logic                      pos_gt0_r;

  logic signed [SW-1:0]      scaled;
  logic [COV_W:0]            pred_sum;
  logic [COV_W+1:0]          r_sh;
  logic                      ge;
  logic signed [AW:0]        delta;
  logic signed [AW+2:0]      est_sum;
  logic [COV_W+GAIN_W-1:0]   cprod;
  logic [GAIN_W-1:0]         inv_gain;
  logic signed [AW:0]        pos;
  logic signed [CW-1:0]      pos_x;
  logic [QW-1:0]             code_full;
  logic [CODE_W-1:0]         code;
  logic [FRAME_W-1:0]        frame;
  logic [FILT_W-1:0]         filt_r;
  logic [GAIN_W-1:0]         gain_out_r;
  logic [CODE_W-1:0]         code_r;
  logic [FRAME_W-1:0]        frame_r;

  // Scale shift with floor, then clamp to the angle limit.
  assign scaled = $signed(prod_r[PW-1:8]);
  always_comb begin
    if (scaled > LIM_S) begin
      sample_nxt = LIM_A;
    end else if (scaled < -LIM_S) begin
      sample_nxt = -LIM_A;
    end else begin
      sample_nxt = $signed(scaled[AW-1:0]);
    end
  end

  // Predict: covariance plus process noise, saturated; then the gain denominator.
  assign pred_sum = {1'b0, cov_r} + {1'b0, proc_noise_r};
  assign err_nxt  = pred_sum[COV_W] ? {COV_W{1'b1}} : pred_sum[COV_W-1:0];
  assign den_nxt  = {1'b0, err_nxt} + {1'b0, meas_noise_r};

  // Restoring division step; the first step tests the whole-one quotient bit.
  assign r_sh    = (cnt_r == '0) ? rem_r : {rem_r[COV_W:0], 1'b0};
  assign ge      = (r_sh >= {1'b0, den_r});
  assign rem_nxt = ge ? (r_sh - {1'b0, den_r}) : r_sh;
  assign sts.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // A zero denominator makes the gain one.
  assign gain_w = (den_r == '0) ? GAIN_ONE : quo_r;

  // Innovation and estimate update with floor on the gain product.
  assign delta   = $signed({sample_r[AW-1], sample_r}) - $signed({est_r[AW-1], est_r});
  assign est_sum = $signed({{3{est_r[AW-1]}}, est_r}) + $signed(kprod_r[KW-1:16]);
  assign est_nxt = $signed(est_sum[AW-1:0]);

  // Covariance shrink by one minus gain, truncated.
  assign inv_gain = GAIN_ONE - gain_r;
  assign cprod    = err_r * inv_gain;
  assign cov_nxt  = cprod[COV_W+15:16];

  // Code: offset estimate times ten, scaled down and saturated.
  assign pos       = $signed({est_r[AW-1], est_r}) + LIM_P;
  assign pos_x     = $signed({{4{pos[AW]}}, pos});
  assign code_full = pos10_r[CW-1:FRAC_BITS];
  always_comb begin
    if (!pos_gt0_r) begin
      code = '0;
    end else if (code_full > QW'(CODE_MAX)) begin
      code = CODE_W'(CODE_MAX);
    end else begin
      code = code_full[CODE_W-1:0];
    end
  end
  assign frame = {FRAME_SYNC0, FRAME_SYNC1, FRAME_CMD, 2'b00, code, FRAME_TAIL};

  // Configuration registers and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_scale_r <= TURN_SCALE_RST;
      meas_noise_r <= MEAS_NOISE_RST;
      proc_noise_r <= PROC_NOISE_RST;
      est_r        <= '0;
      cov_r        <= INIT_ERROR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TURN_SCALE:    turn_scale_r <= cfg_wdata[SCALE_W-1:0];
        REG_INIT_ESTIMATE: est_r <= AW'($signed(cfg_wdata[FILT_W-1:0]));
        REG_INIT_ERROR:    cov_r <= cfg_wdata[COV_W-1:0];
        REG_MEAS_NOISE:    meas_noise_r <= cfg_wdata[COV_W-1:0];
        REG_PROC_NOISE:    proc_noise_r <= cfg_wdata[COV_W-1:0];
        default: begin
        end
      endcase
    end else if (cmd.commit) begin
      est_r <= est_nxt;
      cov_r <= cov_nxt;
    end
  end

  // Divider iteration counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.predict) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Working datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      prod_r <= $signed(in_tdata[RAW_W-1:0]) * turn_scale_r;
    end
    if (cmd.clamp) begin
      sample_r <= sample_nxt;
    end
    if (cmd.predict) begin
      err_r <= err_nxt;
      den_r <= den_nxt;
      rem_r <= {2'b00, err_nxt};
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[GAIN_W-2:0], ge};
    end
    if (cmd.kmul) begin
      gain_r  <= gain_w;
      kprod_r <= $signed({1'b0, gain_w}) * delta;
    end
    if (cmd.code_mul) begin
      pos10_r   <= (pos_x <<< 3) + (pos_x <<< 1);
      pos_gt0_r <= !pos[AW] && (pos != '0);
    end
    if (cmd.out_load) begin
      filt_r     <= est_r[FILT_W-1:0];
      gain_out_r <= gain_r;
      code_r     <= code;
      frame_r    <= frame;
    end
  end

  assign out_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, frame_r, code_r, gain_out_r, filt_r};

endmodule

[rtl/steering_kalman_frame_encoder.sv]
// Steering Kalman frame encoder: a raw steering angle is scaled, clamped to
// plus or minus 779 degrees and smoothed by a scalar Kalman filter, and each
// word yields the filtered angle, the gain, the actuator code and the serial
// frame. One word is worked on at a time: the next input word is taken only
// once the result of the last one has been loaded. The steps are the scale
// multiply, clamp, predict, the restoring divider that forms the gain one
// quotient bit per cycle, the update multiply, estimate commit, code multiply
// and the result load. The result sits in an output register, so input is
// taken again while it waits to be read; the load of the next result waits
// for that register to be free. The user must write configuration only while
// idle; the block itself does not enforce this. Writing the initial estimate
// or initial error also loads the filter state at once.
module steering_kalman_frame_encoder #(
  parameter int FRAC_BITS = skfe_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: raw_steer [31:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [skfe_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: filtered_steer [26:0], gain_now [43:27], steer_code [57:44],
  // command_frame [105:58], zero [111:106]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [skfe_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [skfe_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [skfe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import skfe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  skfe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Arithmetic, filter state and configuration.
  skfe_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

[rtl/skfe_checker.sv]
// Port-level checker for the steering Kalman frame encoder, with its bind.
`include "steering_kalman_frame_encoder_assert.svh"

module skfe_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [skfe_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import skfe_pkg::*;

  // A stalled result word holds.
  `SKFE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // One word in flight: the block is busy right after taking a word.
  `SKFE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken again the cycle after an accept")

  // Frame code bytes match the code field, and the frame constants are in place.
  `SKFE_ASSERT_NOW(a_frame_code, clk, rst_n, out_tvalid, (out_tdata[81:66] == {2'b00, out_tdata[57:44]}) && (out_tdata[105:82] == {FRAME_SYNC0, FRAME_SYNC1, FRAME_CMD}) && (out_tdata[65:58] == FRAME_TAIL), "frame does not match code")

  // Gain never exceeds one and the code stays in range.
  `SKFE_ASSERT_NOW(a_ranges, clk, rst_n, out_tvalid, (out_tdata[43:27] <= GAIN_ONE) && (out_tdata[57:44] <= CODE_W'(CODE_MAX)), "gain or code out of range")

endmodule

bind steering_kalman_frame_encoder skfe_checker u_skfe_checker (.*);
